/* hdl/compose_sequence_trie_walker_core_macros.svh */
// ----------------------------------------------------------------------------
// Compose sequence trie walker - assertion macros
// Shared concurrent assertion forms, clocked on aclk with aresetn as reset.
// ----------------------------------------------------------------------------
`ifndef COMPOSE_SEQUENCE_TRIE_WALKER_CORE_MACROS_SVH
`define COMPOSE_SEQUENCE_TRIE_WALKER_CORE_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds in that cycle.
`define CSTW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: when ante holds, cons holds in the next cycle.
`define CSTW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/cstw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstw_pkg
// Types and constants shared by the trie walker controller, datapath and top.
// ----------------------------------------------------------------------------
package cstw_pkg;

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int LAYER_W  = 3;
    localparam int KEY_W    = 8;
    localparam int IDX_W    = 9;
    localparam int CODE_W   = 16;
    // start index plus offset within a node, both 9 bits
    localparam int SCAN_W   = IDX_W + 1;

    // s_axis_tdata layout, lowest bit first
    localparam int LAYER_LSB = 0;
    localparam int KEY_LSB   = LAYER_LSB + LAYER_W;
    localparam int ADDR_LSB  = KEY_LSB + KEY_W;
    localparam int HDR_BIT   = ADDR_LSB + IDX_W;
    localparam int SYM_BIT   = HDR_BIT + 1;
    localparam int TGT_LSB   = SYM_BIT + 1;
    localparam int WORD_LSB  = TGT_LSB + IDX_W;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = CODE_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_KEY     = 2'd0,
        CMD_WR_NODE = 2'd1,
        CMD_WR_SYM  = 2'd2,
        CMD_RETURN  = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_NOMATCH = 2'd0,
        STAT_PENDING = 2'd1,
        STAT_SYMBOL  = 2'd2,
        STAT_DONE    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        RES_DONE,
        RES_RETURN,
        RES_NOMATCH,
        RES_CHILD,
        RES_SYMBOL
    } res_kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_HEAD_WAIT,
        S_SCAN,
        S_SYM,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic               hdr;
        logic               sym;
        logic [LAYER_W-1:0] layer;
        logic [KEY_W-1:0]   key;
        logic [IDX_W-1:0]   tgt;
    } node_entry_t;

    // controller -> datapath
    typedef struct packed {
        logic      load_item;
        logic      wr_node;
        logic      wr_sym;
        logic      rd_head;
        logic      scan_init;
        logic      scan_step;
        logic      sym_rd;
        logic      set_res;
        res_kind_t res_kind;
        logic      emit;
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hit;
        logic hit_sym;
        logic scan_end;
        logic out_free;
    } dp_sts_t;

endpackage

/* hdl/cstw_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstw_ctrl
// Sequencer for the trie walker: command decode, node scan and result hand-off.
// ----------------------------------------------------------------------------
module cstw_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  cstw_pkg::cmd_t     s_cmd,
    output logic               s_tready,
    input  cstw_pkg::dp_sts_t  sts,
    output cstw_pkg::ctl_cmd_t ctl
);
    import cstw_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        ctl          = '0;
        ctl.res_kind = RES_DONE;
        s_tready     = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ctl.load_item = 1'b1;
                    unique case (s_cmd)
                        CMD_KEY: begin
                            state_next = S_HEAD;
                        end
                        CMD_WR_NODE: begin
                            ctl.wr_node = 1'b1;
                            ctl.set_res = 1'b1;
                            state_next  = S_EMIT;
                        end
                        CMD_WR_SYM: begin
                            ctl.wr_sym  = 1'b1;
                            ctl.set_res = 1'b1;
                            state_next  = S_EMIT;
                        end
                        CMD_RETURN: begin
                            ctl.set_res  = 1'b1;
                            ctl.res_kind = RES_RETURN;
                            state_next   = S_EMIT;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_HEAD: begin
                ctl.rd_head = 1'b1;
                state_next  = S_HEAD_WAIT;
            end
            S_HEAD_WAIT: begin
                ctl.scan_init = 1'b1;
                state_next    = S_SCAN;
            end
            S_SCAN: begin
                ctl.scan_step = 1'b1;
                if (sts.hit) begin
                    if (sts.hit_sym) begin
                        ctl.sym_rd = 1'b1;
                        state_next = S_SYM;
                    end else begin
                        ctl.set_res  = 1'b1;
                        ctl.res_kind = RES_CHILD;
                        state_next   = S_EMIT;
                    end
                end else if (sts.scan_end) begin
                    ctl.set_res  = 1'b1;
                    ctl.res_kind = RES_NOMATCH;
                    state_next   = S_EMIT;
                end
            end
            S_SYM: begin
                ctl.set_res  = 1'b1;
                ctl.res_kind = RES_SYMBOL;
                state_next   = S_EMIT;
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    ctl.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* hdl/cstw_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstw_datapath
// Node and symbol memories, scan pointer, match compare and output register.
// ----------------------------------------------------------------------------
module cstw_datapath #(
    parameter int NODE_DEPTH   = 512,
    parameter int SYMBOL_DEPTH = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wen,
    input  logic [cstw_pkg::IDX_W-1:0]         cfg_wdata,
    input  logic [cstw_pkg::S_TDATA_W-1:0]     s_tdata,
    input  cstw_pkg::ctl_cmd_t                 ctl,
    output cstw_pkg::dp_sts_t                  sts,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [cstw_pkg::STATUS_W-1:0]      m_tuser,
    output logic [cstw_pkg::M_TDATA_W-1:0]     m_tdata
);
    import cstw_pkg::*;

    localparam int NAW = $clog2(NODE_DEPTH);
    localparam int SAW = $clog2(SYMBOL_DEPTH);

    // input fields
    logic [LAYER_W-1:0] in_layer;
    logic [KEY_W-1:0]   in_key;
    logic [IDX_W-1:0]   in_addr;
    logic [CODE_W-1:0]  in_word;
    node_entry_t        in_entry;
    logic               in_node_ok;
    logic               in_sym_ok;

    assign in_layer       = s_tdata[LAYER_LSB +: LAYER_W];
    assign in_key         = s_tdata[KEY_LSB +: KEY_W];
    assign in_addr        = s_tdata[ADDR_LSB +: IDX_W];
    assign in_word        = s_tdata[WORD_LSB +: CODE_W];
    assign in_entry.hdr   = s_tdata[HDR_BIT];
    assign in_entry.sym   = s_tdata[SYM_BIT];
    assign in_entry.layer = in_layer;
    assign in_entry.key   = in_key;
    assign in_entry.tgt   = s_tdata[TGT_LSB +: IDX_W];
    assign in_node_ok     = 32'(in_addr) < NODE_DEPTH;
    assign in_sym_ok      = 32'(in_addr) < SYMBOL_DEPTH;

    logic [IDX_W-1:0]   root_reg;
    logic [IDX_W-1:0]   cur_node_reg;
    logic [LAYER_W-1:0] layer_reg;
    logic [KEY_W-1:0]   key_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg <= '0;
        end else if (cfg_wen) begin
            root_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_item) begin
            layer_reg <= in_layer;
            key_reg   <= in_key;
        end
    end

    // node memory, registered read
    node_entry_t node_mem [NODE_DEPTH];
    node_entry_t node_rd_reg;
    logic        node_rd_en;
    logic [NAW-1:0] node_rd_addr;

    logic [SCAN_W-1:0] scan_idx_reg;
    logic [IDX_W-1:0]  left_reg;
    logic              issued_reg;
    logic              head_ok_reg;
    logic              scan_can_issue;

    assign scan_can_issue = (left_reg != '0) && (32'(scan_idx_reg) < NODE_DEPTH);
    assign node_rd_en     = ctl.rd_head || (ctl.scan_step && scan_can_issue);
    assign node_rd_addr   = ctl.rd_head ? NAW'(cur_node_reg) : NAW'(scan_idx_reg);

    always_ff @(posedge aclk) begin
        if (ctl.wr_node && in_node_ok) begin
            node_mem[NAW'(in_addr)] <= in_entry;
        end
        if (node_rd_en) begin
            node_rd_reg <= node_mem[node_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.rd_head) begin
            head_ok_reg <= 32'(cur_node_reg) < NODE_DEPTH;
        end
        if (ctl.scan_init) begin
            scan_idx_reg <= SCAN_W'(cur_node_reg);
            left_reg     <= (head_ok_reg && node_rd_reg.hdr) ? node_rd_reg.tgt : IDX_W'(1);
        end else if (ctl.scan_step && scan_can_issue) begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
            left_reg     <= left_reg - 1'b1;
        end
    end

    // one read in flight: marks node_rd_reg as a scan candidate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issued_reg <= 1'b0;
        end else if (ctl.scan_init) begin
            issued_reg <= 1'b0;
        end else if (ctl.scan_step) begin
            issued_reg <= scan_can_issue;
        end
    end

    assign sts.hit      = issued_reg && !node_rd_reg.hdr &&
                          (node_rd_reg.layer == layer_reg) && (node_rd_reg.key == key_reg);
    assign sts.hit_sym  = node_rd_reg.sym;
    assign sts.scan_end = !issued_reg && !scan_can_issue;

    // symbol memory, registered read
    logic [CODE_W-1:0] sym_mem [SYMBOL_DEPTH];
    logic [CODE_W-1:0] sym_rd_reg;
    logic              sym_ok_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_sym && in_sym_ok) begin
            sym_mem[SAW'(in_addr)] <= in_word;
        end
        if (ctl.sym_rd) begin
            sym_rd_reg <= sym_mem[SAW'(node_rd_reg.tgt)];
            sym_ok_reg <= 32'(node_rd_reg.tgt) < SYMBOL_DEPTH;
        end
    end

    // pending result
    status_t           res_status_reg;
    logic [CODE_W-1:0] res_code_reg;
    logic              res_move_reg;
    logic              res_root_reg;
    logic [IDX_W-1:0]  res_tgt_reg;

    always_ff @(posedge aclk) begin
        if (ctl.set_res) begin
            res_tgt_reg <= node_rd_reg.tgt;
            case (ctl.res_kind)
                RES_RETURN: begin
                    res_status_reg <= STAT_DONE;
                    res_code_reg   <= '0;
                    res_move_reg   <= 1'b1;
                    res_root_reg   <= 1'b1;
                end
                RES_NOMATCH: begin
                    res_status_reg <= STAT_NOMATCH;
                    res_code_reg   <= '0;
                    res_move_reg   <= 1'b1;
                    res_root_reg   <= 1'b1;
                end
                RES_CHILD: begin
                    res_status_reg <= STAT_PENDING;
                    res_code_reg   <= CODE_W'(1);
                    res_move_reg   <= 1'b1;
                    res_root_reg   <= 1'b0;
                end
                RES_SYMBOL: begin
                    res_status_reg <= STAT_SYMBOL;
                    res_code_reg   <= sym_ok_reg ? sym_rd_reg : '0;
                    res_move_reg   <= 1'b1;
                    res_root_reg   <= 1'b1;
                end
                default: begin
                    res_status_reg <= STAT_DONE;
                    res_code_reg   <= '0;
                    res_move_reg   <= 1'b0;
                    res_root_reg   <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_node_reg <= '0;
        end else if (ctl.emit && res_move_reg) begin
            cur_node_reg <= res_root_reg ? root_reg : res_tgt_reg;
        end
    end

    // output register
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [CODE_W-1:0]   out_code_reg;

    assign sts.out_free = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (ctl.emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.emit) begin
            out_status_reg <= res_status_reg;
            out_code_reg   <= res_code_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = out_code_reg;

endmodule

/* hdl/compose_sequence_trie_walker_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compose_sequence_trie_walker_core
// Compose-key sequence matcher walking a trie held in on-chip node memory.
// ----------------------------------------------------------------------------
// One transfer in gives one transfer out. Write and return-to-root commands
// set their result on accept and hand it to the output register once it is
// free. A key event reads the current node's first entry for its header,
// then scans the node through the single node memory read port one entry
// per cycle, starting at the header entry and stopping at the first match;
// a symbol hit adds a symbol memory lookup. Only one item is in work at a
// time; the output register lets the next item in while a result waits.
// Memories have no reset: entries must be written before a walk reaches
// them. root_index is written through cfg_wen/cfg_wdata; the user must do
// so only while idle, which the block itself does not enforce. It takes
// effect at the next return to the root.
// ----------------------------------------------------------------------------
`include "compose_sequence_trie_walker_core_macros.svh"

module compose_sequence_trie_walker_core #(
    parameter int NODE_DEPTH   = 512,
    parameter int SYMBOL_DEPTH = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // root_index
    input  logic                               cfg_wen,
    input  logic [cstw_pkg::IDX_W-1:0]         cfg_wdata,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata from bit 0: layer[3], keycode[8], addr[9], entry_is_header[1],
    // entry_is_symbol[1], entry_target[9], symbol_word[16], zero pad[1]
    input  logic [cstw_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // tuser: cmd[2]
    input  logic [cstw_pkg::CMD_W-1:0]         s_axis_tuser,
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: code[16]
    output logic [cstw_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // tuser: status[2]
    output logic [cstw_pkg::STATUS_W-1:0]      m_axis_tuser
);
    import cstw_pkg::*;

    ctl_cmd_t ctl;
    dp_sts_t  sts;
    cmd_t     s_cmd;

    // tuser carries the command code directly
    assign s_cmd = cmd_t'(s_axis_tuser);

    // sequencer: decodes the command, steps the scan, hands off the result
    cstw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_axis_tvalid),
        .s_cmd    (s_cmd),
        .s_tready (s_axis_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // memories, scan pointer, compare and output register
    cstw_datapath #(
        .NODE_DEPTH   (NODE_DEPTH),
        .SYMBOL_DEPTH (SYMBOL_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_axis_tdata),
        .ctl       (ctl),
        .sts       (sts),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .m_tuser   (m_axis_tuser),
        .m_tdata   (m_axis_tdata)
    );

    // ---- checks ------------------------------------------------------------
    // a result is only pushed when the output register is free or draining
    `CSTW_ASSERT_NOW(a_emit_into_free_slot, ctl.emit, !m_axis_tvalid || m_axis_tready, "result pushed over an untaken transfer")
    // once a transfer is taken the block is busy with it in the next cycle
    `CSTW_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted twice without a result")
    // memory writes happen only on the accepting cycle
    `CSTW_ASSERT_NOW(a_write_on_accept, ctl.wr_node || ctl.wr_sym, s_axis_tvalid && s_axis_tready, "memory write without an input transfer")

endmodule
